### rtl/core/huffd_pkg.sv
package huffd_pkg;

   // input transaction: one compressed byte
   typedef struct packed {
      logic [7:0] code_byte;
      logic       final_byte;
   } req_type;

   // result transaction: one decoded symbol or an error
   typedef struct packed {
      logic [7:0] symbol;
      logic [1:0] status;
      logic       run_last;
   } rsp_type;

   // result status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW    = 2'd1;
   localparam logic [1:0] STATUS_SINGLE_LEAF = 2'd2;

   // stream phase
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAD,
      PH_DECODE,
      PH_HALT
   } phase_type;

   // back-end sequencer
   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR,
      S_HDR_POP,
      S_PAD,
      S_DEC,
      S_FLUSH
   } eng_state_type;

   localparam int BYTE_BITS  = 8;
   localparam int LAST_BIT   = 7;
   localparam int QUEUE_SLOTS = 2;

endpackage

### rtl/core/huffd_queue.sv
module huffd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  huffd_pkg::req_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output huffd_pkg::req_type out_item
);
   import huffd_pkg::*;

   req_type    slot_ff [QUEUE_SLOTS];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // handshake on both sides
   assign in_ready  = (count_ff != 2'(QUEUE_SLOTS));
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

### rtl/core/huffd_engine.sv
module huffd_engine #(
   parameter int NODE_COUNT  = 512,
   parameter int STACK_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  huffd_pkg::req_type in_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output huffd_pkg::rsp_type rsp_item
);
   import huffd_pkg::*;

   localparam int IW  = $clog2(NODE_COUNT);
   localparam int NFW = $clog2(NODE_COUNT + 1);
   localparam int SIW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   // node table split by field: {leaf, symbol}, left child, right child
   logic [8:0]     node_sym_ff   [NODE_COUNT];
   logic [IW-1:0]  node_left_ff  [NODE_COUNT];
   logic [IW-1:0]  node_right_ff [NODE_COUNT];
   logic [IW-1:0]  stack_ff      [STACK_DEPTH];

   eng_state_type  state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [7:0]     byte_ff, byte_in;
   logic           fin_ff, fin_in;
   logic [3:0]     bit_ff, bit_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [NFW-1:0] nfn_ff, nfn_in;
   logic           prev_leaf_ff, prev_leaf_in;
   logic [7:0]     accum_ff, accum_in;
   logic [3:0]     leaf_left_ff, leaf_left_in;
   logic [31:0]    pad_ff, pad_in;
   logic [2:0]     pad_seen_ff, pad_seen_in;
   logic [IW-1:0]  root_left_ff, root_left_in;
   logic [IW-1:0]  root_right_ff, root_right_in;
   logic [IW-1:0]  walk_left_ff, walk_left_in;
   logic [IW-1:0]  walk_right_ff, walk_right_in;
   logic           pend_valid_ff, pend_valid_in;
   rsp_type        pend_ff, pend_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;

   // read data registers
   logic [8:0]     rd_sym_ff;
   logic [IW-1:0]  rd_left_ff, rd_right_ff;
   logic [IW-1:0]  stk_rd_ff;

   // memory ports
   logic           sym_we, left_we, right_we, stk_we, node_re, stk_re;
   logic [IW-1:0]  sym_waddr, left_waddr, right_waddr, node_raddr;
   logic [8:0]     sym_wdata;
   logic [IW-1:0]  left_wdata, right_wdata, stk_wdata;
   logic [SIW-1:0] stk_waddr, stk_raddr;

   // shared step helpers
   logic           cur_bit, advance, alloc_go, emit_go, flush_go, done;
   logic [SPW-1:0] alloc_sp;
   rsp_type        emit_item;
   logic [IW-1:0]  nfn_idx, kid_left, kid_right;
   logic [7:0]     acc_next;
   logic [2:0]     dec_pos;
   logic [3:0]     cut, pos_sum;
   logic           out_free, suppress, dec_leaf, stall;

   assign in_ready  = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      byte_in       = byte_ff;
      fin_in        = fin_ff;
      bit_in        = bit_ff;
      sp_in         = sp_ff;
      nfn_in        = nfn_ff;
      prev_leaf_in  = prev_leaf_ff;
      accum_in      = accum_ff;
      leaf_left_in  = leaf_left_ff;
      pad_in        = pad_ff;
      pad_seen_in   = pad_seen_ff;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;
      walk_left_in  = walk_left_ff;
      walk_right_in = walk_right_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;

      sym_we = 1'b0;  sym_waddr = '0;  sym_wdata = '0;
      left_we = 1'b0; left_waddr = '0; left_wdata = '0;
      right_we = 1'b0; right_waddr = '0; right_wdata = '0;
      stk_we = 1'b0;  stk_waddr = '0;  stk_wdata = '0;
      node_re = 1'b0; node_raddr = '0;
      stk_re = 1'b0;  stk_raddr = '0;

      advance   = 1'b0;
      alloc_go  = 1'b0;
      alloc_sp  = sp_ff;
      emit_go   = 1'b0;
      emit_item = '0;
      flush_go  = 1'b0;
      done      = 1'b0;

      cur_bit  = byte_ff[3'(LAST_BIT) - bit_ff[2:0]];
      nfn_idx  = IW'(nfn_ff);
      acc_next = {accum_ff[6:0], cur_bit};

      // decode: resolve the node reached by the previous bit
      dec_pos   = 3'(bit_ff - 4'd1);
      cut       = (pad_ff >= 32'(BYTE_BITS)) ? 4'(BYTE_BITS) : pad_ff[3:0];
      pos_sum   = {1'b0, dec_pos} + cut;
      suppress  = fin_ff && (pos_sum >= 4'(BYTE_BITS));
      dec_leaf  = (bit_ff != 4'd0) && rd_sym_ff[8];
      stall     = dec_leaf && !suppress && pend_valid_ff && !out_free;
      if (dec_leaf) begin
         kid_left  = root_left_ff;
         kid_right = root_right_ff;
      end else if (bit_ff != 4'd0) begin
         kid_left  = rd_left_ff;
         kid_right = rd_right_ff;
      end else begin
         kid_left  = walk_left_ff;
         kid_right = walk_right_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               byte_in = in_item.code_byte;
               fin_in  = in_item.final_byte;
               bit_in  = 4'd0;
               case (phase_ff)
                  PH_HEADER: state_in = S_HDR;
                  PH_PAD:    state_in = S_PAD;
                  PH_DECODE: state_in = S_DEC;
                  default:   state_in = S_FLUSH;
               endcase
            end
         end

         S_HDR: begin
            if (leaf_left_ff != 4'd0) begin
               // shift in one symbol bit of the current leaf
               accum_in     = acc_next;
               leaf_left_in = leaf_left_ff - 4'd1;
               advance      = 1'b1;
               if (leaf_left_ff == 4'd1) begin
                  sym_we    = 1'b1;
                  sym_waddr = IW'(nfn_ff - NFW'(1));
                  sym_wdata = {1'b1, acc_next};
                  if (sp_ff == '0) begin
                     advance  = 1'b0;
                     state_in = S_FLUSH;
                     if (nfn_ff == NFW'(1)) begin
                        emit_go          = 1'b1;
                        emit_item.status = STATUS_SINGLE_LEAF;
                        phase_in         = PH_HALT;
                     end else begin
                        phase_in = PH_PAD;
                     end
                  end
               end
            end else if (nfn_ff >= NFW'(NODE_COUNT)) begin
               emit_go          = 1'b1;
               emit_item.status = STATUS_OVERFLOW;
               phase_in         = PH_HALT;
               state_in         = S_FLUSH;
            end else if (nfn_ff != '0 && prev_leaf_ff && sp_ff != '0) begin
               // right child: fetch the pending parent first
               stk_re    = 1'b1;
               stk_raddr = SIW'(sp_ff - SPW'(1));
               state_in  = S_HDR_POP;
            end else begin
               if (nfn_ff != '0 && !prev_leaf_ff) begin
                  left_we    = 1'b1;
                  left_waddr = IW'(nfn_ff - NFW'(1));
                  left_wdata = nfn_idx;
                  if (left_waddr == '0) begin
                     root_left_in = nfn_idx;
                  end
               end
               alloc_go = 1'b1;
               alloc_sp = sp_ff;
            end
         end

         S_HDR_POP: begin
            right_we    = 1'b1;
            right_waddr = stk_rd_ff;
            right_wdata = nfn_idx;
            if (stk_rd_ff == '0) begin
               root_right_in = nfn_idx;
            end
            alloc_go = 1'b1;
            alloc_sp = sp_ff - SPW'(1);
            sp_in    = alloc_sp;
         end

         S_PAD: begin
            case (pad_seen_ff[1:0])
               2'd0:    pad_in[7:0]   = byte_ff;
               2'd1:    pad_in[15:8]  = byte_ff;
               2'd2:    pad_in[23:16] = byte_ff;
               default: pad_in[31:24] = byte_ff;
            endcase
            pad_seen_in = pad_seen_ff + 3'd1;
            if (pad_seen_ff == 3'd3) begin
               phase_in      = PH_DECODE;
               walk_left_in  = root_left_ff;
               walk_right_in = root_right_ff;
            end
            state_in = S_FLUSH;
         end

         S_DEC: begin
            if (!stall) begin
               walk_left_in  = kid_left;
               walk_right_in = kid_right;
               if (dec_leaf && !suppress) begin
                  emit_go          = 1'b1;
                  emit_item.symbol = rd_sym_ff[7:0];
                  emit_item.status = STATUS_OK;
               end
               if (bit_ff != 4'(BYTE_BITS)) begin
                  node_re    = 1'b1;
                  node_raddr = cur_bit ? kid_right : kid_left;
                  bit_in     = bit_ff + 4'd1;
               end else begin
                  state_in = S_FLUSH;
               end
            end
         end

         S_FLUSH: begin
            if (!pend_valid_ff) begin
               done = 1'b1;
            end else if (out_free) begin
               flush_go = 1'b1;
               done     = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // allocate the next node in pre-order
      if (alloc_go) begin
         if (cur_bit && alloc_sp == SPW'(STACK_DEPTH)) begin
            emit_go          = 1'b1;
            emit_item.status = STATUS_OVERFLOW;
            phase_in         = PH_HALT;
            state_in         = S_FLUSH;
         end else begin
            sym_we       = 1'b1;
            sym_waddr    = nfn_idx;
            sym_wdata    = {!cur_bit, 8'd0};
            nfn_in       = nfn_ff + NFW'(1);
            prev_leaf_in = !cur_bit;
            advance      = 1'b1;
            if (cur_bit) begin
               stk_we    = 1'b1;
               stk_waddr = SIW'(alloc_sp);
               stk_wdata = nfn_idx;
               sp_in     = alloc_sp + SPW'(1);
            end else begin
               accum_in     = 8'd0;
               leaf_left_in = 4'(BYTE_BITS);
            end
         end
      end

      // next header bit, or end of byte
      if (advance) begin
         if (bit_ff == 4'(LAST_BIT)) begin
            state_in = S_FLUSH;
         end else begin
            bit_in   = bit_ff + 4'd1;
            state_in = S_HDR;
         end
      end

      // a new result displaces the held one toward the output
      if (emit_go) begin
         if (pend_valid_ff) begin
            out_valid_in     = 1'b1;
            out_in           = pend_ff;
            out_in.run_last  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = emit_item;
      end

      // end of byte: the held result is the last one of the byte
      if (flush_go) begin
         out_valid_in    = 1'b1;
         out_in          = pend_ff;
         out_in.run_last = 1'b1;
         pend_valid_in   = 1'b0;
      end

      if (done) begin
         state_in = S_IDLE;
         if (fin_ff) begin
            phase_in     = PH_HEADER;
            sp_in        = '0;
            nfn_in       = '0;
            prev_leaf_in = 1'b0;
            accum_in     = 8'd0;
            leaf_left_in = 4'd0;
            pad_in       = 32'd0;
            pad_seen_in  = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_HEADER;
         sp_ff         <= '0;
         nfn_ff        <= '0;
         prev_leaf_ff  <= 1'b0;
         accum_ff      <= 8'd0;
         leaf_left_ff  <= 4'd0;
         pad_ff        <= 32'd0;
         pad_seen_ff   <= 3'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         sp_ff         <= sp_in;
         nfn_ff        <= nfn_in;
         prev_leaf_ff  <= prev_leaf_in;
         accum_ff      <= accum_in;
         leaf_left_ff  <= leaf_left_in;
         pad_ff        <= pad_in;
         pad_seen_ff   <= pad_seen_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      fin_ff        <= fin_in;
      bit_ff        <= bit_in;
      root_left_ff  <= root_left_in;
      root_right_ff <= root_right_in;
      walk_left_ff  <= walk_left_in;
      walk_right_ff <= walk_right_in;
      pend_ff       <= pend_in;
      out_ff        <= out_in;
   end

   // node table and pending stack
   always_ff @(posedge clock) begin
      if (sym_we) begin
         node_sym_ff[sym_waddr] <= sym_wdata;
      end
      if (left_we) begin
         node_left_ff[left_waddr] <= left_wdata;
      end
      if (right_we) begin
         node_right_ff[right_waddr] <= right_wdata;
      end
      if (stk_we) begin
         stack_ff[stk_waddr] <= stk_wdata;
      end
      if (node_re) begin
         rd_sym_ff   <= node_sym_ff[node_raddr];
         rd_left_ff  <= node_left_ff[node_raddr];
         rd_right_ff <= node_right_ff[node_raddr];
      end
      if (stk_re) begin
         stk_rd_ff <= stack_ff[stk_raddr];
      end
   end

endmodule

### rtl/core/huffman_stream_decoder_unit.sv
// Huffman stream decoder.
// req channel: one compressed byte per transaction (code_byte, MSB first),
// final_byte set on the last byte of a stream. rsp channel: decoded symbols,
// or one error result (node table overflow, single-leaf tree) with symbol 0.
// run_last marks the last result caused by a byte; a byte may cause none.
// Bytes land in a two-entry queue; a sequencer behind it takes one byte at a
// time, accepting it in its idle state. Tree header bytes then take one step
// per bit, plus one more for each node that starts a right subtree
// (pending-stack read), then a finish step; bits after the tree is
// complete are skipped. Padding-count bytes take a store step and a finish
// step. Data bytes take one node-table read per bit, one step to resolve the
// last bit and one to finish. Each result waits
// in a holding register until the next leaf of its byte or the end of the
// byte decides run_last, then moves to the output register and is presented
// on rsp from the following cycle. When rsp_ready is low, the sequencer stops
// on the next result it cannot place and the queue fills, then req_ready
// drops. Reset empties the queue and output and returns to the header phase;
// node table contents are not cleared. After a final byte the stream state
// returns to reset values.
module huffman_stream_decoder_unit #(
   parameter int NODE_COUNT  = 512,
   parameter int STACK_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  huffd_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output huffd_pkg::rsp_type rsp_item
);
   import huffd_pkg::*;

   logic    q_valid, q_ready;
   req_type q_item;

   // front: input queue
   huffd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   // back: tree build and decode
   huffd_engine #(
      .NODE_COUNT  (NODE_COUNT),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // status is always a defined code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == STATUS_OK ||
                     rsp_item.status == STATUS_OVERFLOW ||
                     rsp_item.status == STATUS_SINGLE_LEAF))
      else $error("undefined status code");

   // an error result carries symbol zero and closes its byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != STATUS_OK) |->
         (rsp_item.symbol == 8'd0 && rsp_item.run_last))
      else $error("malformed error result");

endmodule

### sim/tb_huffman_stream_decoder_unit.sv
`timescale 1ns / 1ps

module tb_huffman_stream_decoder_unit;
   import huffd_pkg::*;

   localparam int NODES     = 512;
   localparam int STACK_MAX = 256;
   localparam int CYCLE_CAP = 600000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   huffman_stream_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder shadow state
   logic [26:0] tree_mem [NODES];
   logic [8:0]  right_stack [STACK_MAX];
   phase_type   sh_phase;
   int unsigned sh_sp, sh_free, sh_sym, sh_sym_bits, sh_pad, sh_pad_seen, sh_walk;

   rsp_type symbols_due[$];
   int      fail_count = 0;
   int      bytes_sent = 0;
   int      symbols_seen = 0;
   int      streams_sent = 0;
   int      cycles = 0;

   // outgoing bit buffer for building streams
   bit      bit_buf[$];
   int      burst_left = 0;

   task automatic shadow_clear();
      for (int i = 0; i < NODES; i++) tree_mem[i] = '0;
      for (int i = 0; i < STACK_MAX; i++) right_stack[i] = '0;
      sh_phase = PH_HEADER;
      sh_sp = 0; sh_free = 0; sh_sym = 0; sh_sym_bits = 0;
      sh_pad = 0; sh_pad_seen = 0; sh_walk = 0;
   endtask

   function automatic int unsigned clip_idx(int unsigned i);
      return (i < NODES) ? i : 0;
   endfunction

   // one header bit; returns a status code, STATUS_OK to go on
   function automatic logic [1:0] tree_bit(bit b);
      int unsigned n, prev, p;
      if (sh_sym_bits > 0) begin
         sh_sym = ((sh_sym << 1) | b) & 8'hFF;
         sh_sym_bits--;
         if (sh_sym_bits == 0) begin
            n = clip_idx(sh_free - 1);
            tree_mem[n][25:18] = tree_mem[n][25:18] | sh_sym[7:0];
            if (sh_sp == 0) begin
               if (sh_free == 1) return STATUS_SINGLE_LEAF;
               sh_phase = PH_PAD;
            end
         end
         return STATUS_OK;
      end
      if (sh_free >= NODES) return STATUS_OVERFLOW;
      n = sh_free;
      if (n > 0) begin
         prev = clip_idx(n - 1);
         if (!tree_mem[prev][26]) begin
            tree_mem[prev][17:9] = tree_mem[prev][17:9] | n[8:0];
         end else if (sh_sp > 0) begin
            sh_sp--;
            p = clip_idx(32'(right_stack[sh_sp]));
            tree_mem[p][8:0] = tree_mem[p][8:0] | n[8:0];
         end
      end
      if (b) begin
         if (sh_sp >= STACK_MAX) return STATUS_OVERFLOW;
         tree_mem[n] = '0;
         right_stack[sh_sp] = n[8:0];
         sh_sp++;
      end else begin
         tree_mem[n] = 27'h0;
         tree_mem[n][26] = 1'b1;
         sh_sym = 0;
         sh_sym_bits = 8;
      end
      sh_free = n + 1;
      return STATUS_OK;
   endfunction

   // work out the results one accepted byte causes
   task automatic predict_byte(logic [7:0] cb, logic fin);
      rsp_type     outs[$];
      rsp_type     r;
      logic [1:0]  st;
      logic [26:0] e;
      int unsigned cut;
      if (sh_phase == PH_HEADER) begin
         for (int b = 7; b >= 0 && sh_phase == PH_HEADER; b--) begin
            st = tree_bit(cb[b]);
            if (st != STATUS_OK) begin
               r = '{symbol: 8'h00, status: st, run_last: 1'b0};
               outs.push_back(r);
               sh_phase = PH_HALT;
            end
         end
      end else if (sh_phase == PH_PAD) begin
         sh_pad = sh_pad | (32'(cb) << (8 * (sh_pad_seen & 3)));
         sh_pad_seen++;
         if (sh_pad_seen >= 4) begin
            sh_phase = PH_DECODE;
            sh_walk = 0;
         end
      end else if (sh_phase == PH_DECODE) begin
         cut = (sh_pad >= 8) ? 8 : sh_pad;
         for (int i = 0; i < 8; i++) begin
            e = tree_mem[clip_idx(sh_walk)];
            sh_walk = clip_idx(32'(cb[7-i] ? e[8:0] : e[17:9]));
            e = tree_mem[sh_walk];
            if (e[26]) begin
               if (!(fin && i >= 8 - cut)) begin
                  r = '{symbol: e[25:18], status: STATUS_OK, run_last: 1'b0};
                  outs.push_back(r);
               end
               sh_walk = 0;
            end
         end
      end
      if (outs.size() > 0) outs[outs.size()-1].run_last = 1'b1;
      foreach (outs[k]) symbols_due.push_back(outs[k]);
      if (fin) shadow_clear();
   endtask

   // send one byte; the sender runs in bursts with random gaps between them
   task automatic send_byte(logic [7:0] cb, logic fin);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_item  <= '{code_byte: cb, final_byte: fin};
      do @(posedge clock); while (!req_ready);
      predict_byte(cb, fin);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic push_bits(logic [31:0] v, int n);
      for (int i = n - 1; i >= 0; i--) bit_buf.push_back(v[i]);
   endtask

   // flush the bit buffer as bytes; leftover bits are filled at random
   task automatic send_bit_buf(logic fin_last);
      logic [7:0] cb;
      while (bit_buf.size() > 0) begin
         for (int i = 7; i >= 0; i--)
            cb[i] = (bit_buf.size() > 0) ? bit_buf.pop_front() : 1'($urandom_range(0, 1));
         send_byte(cb, fin_last && bit_buf.size() == 0);
      end
   endtask

   task automatic send_pad_count(logic [31:0] pad);
      for (int i = 0; i < 4; i++) send_byte(pad[8*i +: 8], 1'b0);
   endtask

   // random pre-order tree header with the root an internal node
   task automatic push_random_tree(int max_int);
      int need = 1;
      int ints = 0;
      while (need > 0) begin
         if (ints == 0 || (ints < max_int && $urandom_range(0, 1))) begin
            bit_buf.push_back(1'b1);
            need++;
            ints++;
         end else begin
            bit_buf.push_back(1'b0);
            push_bits($urandom_range(0, 255), 8);
            need--;
         end
      end
   endtask

   // hold the sender until every expected symbol has come out
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (symbols_due.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic test_two_leaf_stream();
      // root with leaves 0x00 and 0xFF
      push_bits(32'd1, 1); push_bits(32'd0, 1); push_bits(32'h00, 8); push_bits(32'd0, 1);
      push_bits(32'hFF, 8);
      send_bit_buf(1'b0);
      send_pad_count(32'd3);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      streams_sent++;
      drain();
   endtask

   task automatic test_full_pad_suppress();
      push_random_tree(3);
      send_bit_buf(1'b0);
      send_pad_count(32'hFFFF_FFFF);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      streams_sent++;
   endtask

   task automatic test_single_leaf();
      push_bits(32'd0, 1); push_bits(32'h81, 8);
      send_bit_buf(1'b0);
      // halted: no results from here on, the final byte included
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      streams_sent++;
   endtask

   task automatic test_stack_overflow();
      for (int i = 0; i < 33; i++) send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      streams_sent++;
      drain();
   endtask

   task automatic test_node_overflow();
      // a chain of internal/leaf pairs keeps the stack shallow
      for (int i = 0; i < 257; i++) begin
         push_bits(32'd1, 1); push_bits(32'd0, 1); push_bits(32'(i[7:0]), 8);
      end
      send_bit_buf(1'b0);
      send_byte(8'h55, 1'b1);
      streams_sent++;
      drain();
   endtask

   task automatic test_truncated();
      push_bits(32'd1, 1); push_bits(32'd0, 1);
      send_bit_buf(1'b1);
      push_random_tree(2);
      send_bit_buf(1'b0);
      send_byte(8'h07, 1'b0);
      send_byte(8'h00, 1'b1);
      streams_sent += 2;
   endtask

   task automatic test_random_streams();
      int kind, nd;
      logic [31:0] pad;
      while (bytes_sent < 430) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // raw noise
            nd = $urandom_range(1, 10);
            for (int i = 0; i < nd; i++)
               send_byte(8'($urandom_range(0, 255)), i == nd - 1);
         end else if (kind == 1) begin
            // broken: ends within the padding count, before any data byte
            push_random_tree($urandom_range(1, 4));
            send_bit_buf(1'b0);
            nd = $urandom_range(0, 3);
            for (int i = 0; i <= nd; i++) send_byte(8'($urandom_range(0, 255)), i == nd);
         end else begin
            push_random_tree(($urandom_range(0, 5) == 0) ? $urandom_range(8, 20)
                                                         : $urandom_range(1, 6));
            send_bit_buf(1'b0);
            pad = ($urandom_range(0, 4) == 0) ? (32'($urandom()) | 32'h100)
                                              : $urandom_range(0, 9);
            send_pad_count(pad);
            nd = $urandom_range(1, 25);
            for (int i = 0; i < nd; i++)
               send_byte(8'($urandom_range(0, 255)), i == nd - 1);
         end
         streams_sent++;
         if ($urandom_range(0, 3) == 0) drain();
      end
   endtask

   // receiver stall pattern: runs of ready/not ready of random length
   int  ready_run = 0;
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_run <= $urandom_range(1, 25);
         rsp_ready <= ($urandom_range(0, 9) < 7);
      end else begin
         ready_run <= ready_run - 1;
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (symbols_due.size() == 0) begin
            $error("unexpected result symbol=%0h status=%0d", rsp_item.symbol,
                   rsp_item.status);
            fail_count++;
         end else begin
            want = symbols_due.pop_front();
            symbols_seen++;
            if (rsp_item.symbol !== want.symbol) begin
               $error("symbol: expected %0h actual %0h", want.symbol, rsp_item.symbol);
               fail_count++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.run_last !== want.run_last) begin
               $error("run_last: expected %0d actual %0d", want.run_last,
                      rsp_item.run_last);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      shadow_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_two_leaf_stream();
      test_full_pad_suppress();
      test_single_leaf();
      test_stack_overflow();
      test_node_overflow();
      test_truncated();
      drain();
      test_random_streams();
      drain();
      if (symbols_due.size() != 0) begin
         $error("%0d expected results never arrived", symbols_due.size());
         fail_count++;
      end
      $display("Covered %0d streams in %0d bytes with %0d results checked,", streams_sent,
               bytes_sent, symbols_seen);
      $display("including both overflows, a single-leaf tree and truncated streams.");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/huffd_pkg.sv
rtl/core/huffd_queue.sv
rtl/core/huffd_engine.sv
rtl/core/huffman_stream_decoder_unit.sv
sim/tb_huffman_stream_decoder_unit.sv
